@@ rtl/core/osh_pkg.sv @@
// Package for the operation statistics histogram counter.
// Holds field widths, register indexes, operation codes and reset values.
// No dependencies; every other file of the block imports it.
package osh_pkg;

  // Default sizes for the top-level parameters.
  localparam int NUM_OPS_DEF      = 32;
  localparam int NUM_BOUNDS_DEF   = 6;
  localparam int COUNTER_BITS_DEF = 64;

  // Fixed field widths of the channels and the configuration port.
  localparam int MAX_BOUNDS   = 6;
  localparam int MASK_W       = 32;
  localparam int BOUND_W      = 32;
  localparam int CODE_W       = 6;
  localparam int VAL_W        = 64;
  localparam int RIDX_W       = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // Item kinds.
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OP_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_0 = 3'd1;

  // Operation codes that feed the transfer histograms.
  localparam logic [CODE_W-1:0] OP_READ_A  = 6'd12;
  localparam logic [CODE_W-1:0] OP_READ_B  = 6'd29;
  localparam logic [CODE_W-1:0] OP_WRITE_A = 6'd13;
  localparam logic [CODE_W-1:0] OP_WRITE_B = 6'd28;

  // Transfer direction, used as the histogram and total select.
  typedef enum logic {
    DIR_READ  = 1'b0,
    DIR_WRITE = 1'b1
  } dir_t;

  typedef logic [BOUND_W-1:0] bound_t;

  // Reset values of the bucket bounds.
  localparam bound_t BOUND_RESET [MAX_BOUNDS] = '{
    32'd4096, 32'd8192, 32'd16384, 32'd65536, 32'd131072, 32'd262144
  };

endpackage

@@ rtl/core/osh_in_if.sv @@
// Input channel interface of the operation statistics block.
// Carries valid, ready and one item; widths come from osh_pkg.
interface osh_in_if
  import osh_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CODE_W-1:0] op_code;
  logic [VAL_W-1:0]  duration;
  logic [VAL_W-1:0]  byte_count;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, kind, op_code, duration, byte_count, read_index,
                  input ready);
  modport sink   (input valid, kind, op_code, duration, byte_count, read_index,
                  output ready);
endinterface

@@ rtl/core/osh_out_if.sv @@
// Result channel interface of the operation statistics block.
// Carries valid, ready and one read result; widths come from osh_pkg.
interface osh_out_if
  import osh_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  logic             bad_index;

  modport source (output valid, read_value, bad_index, input ready);
  modport sink   (input valid, read_value, bad_index, output ready);
endinterface

@@ rtl/core/op_stats_histogram_counter.sv @@
// Top level of the operation statistics block with cumulative size histograms.
// Depends on osh_pkg and the channel interfaces osh_in_if and osh_out_if.
//
//   channel  | dir | payload                                      | accepted when
//   in_ch    | in  | kind, op_code, duration, byte_count, read_idx | valid & ready
//   out_ch   | out | read_value, bad_index                        | valid & ready
//   cfg_*    | in  | cfg_index, cfg_wdata                         | cfg_we
//
// One beat is taken every cycle while no read beat is held in the stage. A beat
// is registered with the per-operation entry read from the counter RAM, updated
// in the next cycle, and a read beat passes through the stage register to the
// output register. The RAM read-modify-write sets the rate; back-to-back updates
// of one entry are forwarded. Reset is synchronous and clears all counters at
// once: the RAM entries carry valid bits, so there is no clearing pass. A stalled
// result holds the next read beat and all behind it; a staged event still goes.
module op_stats_histogram_counter
  import osh_pkg::*;
#(
  parameter int NUM_OPS      = NUM_OPS_DEF,
  parameter int NUM_BOUNDS   = NUM_BOUNDS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  osh_in_if.sink                in_ch,
  osh_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CB       = COUNTER_BITS;
  localparam int NBK      = NUM_BOUNDS + 1;
  localparam int BASE_DUR = NUM_OPS;
  localparam int BASE_BKT = 2 * NUM_OPS;
  localparam int BASE_CNT = BASE_BKT + 2 * NBK;
  localparam int BASE_SUM = BASE_CNT + 2;
  localparam int LAST_IDX = BASE_SUM + 1;
  localparam int IW       = $clog2(LAST_IDX + 1);
  localparam int OA       = $clog2(NUM_OPS);
  localparam int BKW      = $clog2(2 * NBK);

  // Configuration registers; only the bounds in use are kept.
  logic [MASK_W-1:0] mask_r;
  bound_t            bound_r [NUM_BOUNDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '1;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        bound_r[i] <= BOUND_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_OP_MASK) begin
        mask_r <= cfg_wdata;
      end
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_BOUND_0 + i)) begin
          bound_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // Handshake and stage control.
  logic s1_v_r, s1_v_nxt;
  logic s1_go;
  logic in_acc;
  logic out_v_r, out_v_nxt;

  logic              s1_kind_r;
  logic [CODE_W-1:0] s1_code_r;
  logic [VAL_W-1:0]  s1_dur_r;
  logic [VAL_W-1:0]  s1_bytes_r;
  logic [IW-1:0]     s1_idx_r;

  assign s1_go       = s1_v_r && ((s1_kind_r == KIND_EVENT) || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Counter RAM address for the incoming beat: the op code for events, the
  // call or duration slot for reads.
  logic [IW-1:0] in_idx;
  logic [IW-1:0] in_idx_dur;
  logic [OA-1:0] rd_addr;

  assign in_idx     = IW'(in_ch.read_index);
  assign in_idx_dur = in_idx - IW'(BASE_DUR);

  always_comb begin
    if (in_ch.kind == KIND_EVENT) begin
      rd_addr = in_ch.op_code[OA-1:0];
    end else if (in_idx < IW'(BASE_DUR)) begin
      rd_addr = in_idx[OA-1:0];
    end else begin
      rd_addr = in_idx_dur[OA-1:0];
    end
  end

  // Per-operation call and duration counters, one RAM word per code.
  logic [2*CB-1:0] ops_mem_r [NUM_OPS];
  logic            ops_vld_r [NUM_OPS];
  logic [2*CB-1:0] ops_rd_r;
  logic            ent_vld_r;
  logic            fwd_r;
  logic [2*CB-1:0] fwd_data_r;

  logic            wr_en;
  logic [OA-1:0]   wr_addr;
  logic [2*CB-1:0] wr_data;

  assign wr_addr = s1_code_r[OA-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ops_rd_r <= ops_mem_r[rd_addr];
    end
    if (wr_en) begin
      ops_mem_r[wr_addr] <= wr_data;
    end
  end

  // Stage register with forwarding of a write that lands on the same edge.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= in_ch.kind;
      s1_code_r  <= in_ch.op_code;
      s1_dur_r   <= in_ch.duration;
      s1_bytes_r <= in_ch.byte_count;
      s1_idx_r   <= in_idx;
      ent_vld_r  <= ops_vld_r[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign s1_v_nxt = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);

  // Event decode.
  logic [2*CB-1:0] cur;
  logic [CB-1:0]   cur_call, cur_dur;
  logic            code_ok, code_en, is_rd, is_wr, hist_en;
  dir_t            dir;

  always_comb begin
    if (fwd_r) begin
      cur = fwd_data_r;
    end else if (ent_vld_r) begin
      cur = ops_rd_r;
    end else begin
      cur = '0;
    end
    cur_call = cur[2*CB-1:CB];
    cur_dur  = cur[CB-1:0];
    code_ok  = {1'b0, s1_code_r} < (CODE_W + 1)'(NUM_OPS);
    code_en  = s1_code_r[CODE_W-1] || mask_r[s1_code_r[CODE_W-2:0]];
    is_rd    = (s1_code_r == OP_READ_A) || (s1_code_r == OP_READ_B);
    is_wr    = (s1_code_r == OP_WRITE_A) || (s1_code_r == OP_WRITE_B);
    dir      = is_wr ? DIR_WRITE : DIR_READ;
    wr_en    = s1_go && (s1_kind_r == KIND_EVENT) && code_ok && code_en;
    hist_en  = s1_go && (s1_kind_r == KIND_EVENT) && code_ok && (is_rd || is_wr);
    wr_data  = {cur_call + CB'(1), cur_dur + s1_dur_r[CB-1:0]};
  end

  // Bucket hit pattern: every bucket from the first bound that holds the
  // byte count up through the overflow bucket.
  logic [NBK-1:0] hit;

  always_comb begin
    logic run;
    run = 1'b0;
    for (int b = 0; b < NUM_BOUNDS; b++) begin
      run    = run || (s1_bytes_r <= VAL_W'(bound_r[b]));
      hit[b] = run;
    end
    hit[NBK-1] = 1'b1;
  end

  // Histogram buckets (read direction first) and transfer totals.
  logic [CB-1:0] bkt_r [2*NBK];
  logic [CB-1:0] cnt_r [2];
  logic [CB-1:0] sum_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2 * NBK; k++) begin
        bkt_r[k] <= '0;
      end
      for (int d = 0; d < 2; d++) begin
        cnt_r[d] <= '0;
        sum_r[d] <= '0;
      end
    end else if (hist_en) begin
      for (int b = 0; b < NBK; b++) begin
        if (hit[b]) begin
          if (dir == DIR_WRITE) begin
            bkt_r[NBK + b] <= bkt_r[NBK + b] + CB'(1);
          end else begin
            bkt_r[b] <= bkt_r[b] + CB'(1);
          end
        end
      end
      cnt_r[dir] <= cnt_r[dir] + CB'(1);
      sum_r[dir] <= sum_r[dir] + s1_bytes_r[CB-1:0];
    end
  end

  // Valid bits of the counter RAM.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_OPS; k++) begin
        ops_vld_r[k] <= 1'b0;
      end
    end else if (wr_en) begin
      ops_vld_r[wr_addr] <= 1'b1;
    end
  end

  // Read beat: pick the addressed statistic.
  logic [IW-1:0]    bkt_off;
  logic [BKW-1:0]   bkt_sel;
  logic [VAL_W-1:0] rv_nxt;
  logic             bad_nxt;

  assign bkt_off = s1_idx_r - IW'(BASE_BKT);
  assign bkt_sel = bkt_off[BKW-1:0];

  always_comb begin
    bad_nxt = 1'b0;
    if (s1_idx_r > IW'(LAST_IDX)) begin
      rv_nxt  = '0;
      bad_nxt = 1'b1;
    end else if (s1_idx_r < IW'(BASE_DUR)) begin
      rv_nxt = VAL_W'(cur_call);
    end else if (s1_idx_r < IW'(BASE_BKT)) begin
      rv_nxt = VAL_W'(cur_dur);
    end else if (s1_idx_r < IW'(BASE_CNT)) begin
      rv_nxt = VAL_W'(bkt_r[bkt_sel]);
    end else if (s1_idx_r < IW'(BASE_SUM)) begin
      rv_nxt = VAL_W'(cnt_r[s1_idx_r[0]]);
    end else begin
      rv_nxt = VAL_W'(sum_r[s1_idx_r[0]]);
    end
  end

  // Output register.
  logic [VAL_W-1:0] read_value_r;
  logic             bad_index_r;

  always_comb begin
    if (s1_go && (s1_kind_r == KIND_READ)) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_kind_r == KIND_READ)) begin
      read_value_r <= rv_nxt;
      bad_index_r  <= bad_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.read_value = read_value_r;
  assign out_ch.bad_index  = bad_index_r;

`ifndef SYNTH
  // A read beat leaving the stage always lands in the output register.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_kind_r == KIND_READ)) |=> out_v_r)
    else $error("read beat produced no result");

  // The overflow bucket counts every transfer of its direction.
  a_ovf_read: assert property (@(posedge clk) disable iff (!rst_n)
    bkt_r[NBK-1] == cnt_r[0])
    else $error("read overflow bucket differs from read count");

  a_ovf_write: assert property (@(posedge clk) disable iff (!rst_n)
    bkt_r[2*NBK-1] == cnt_r[1])
    else $error("write overflow bucket differs from write count");

  // A stalled beat keeps its place and its index.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_idx_r)))
    else $error("stalled beat was lost or changed");
`endif

endmodule
